/* design/scba_pkg.sv */
// Shared types, field widths and status codes of the size-class block allocator.
package scba_pkg;

	localparam int ADDR_W     = 20;
	localparam int SIZE_W     = 16;
	localparam int LIMIT_W    = 21;
	localparam int STATUS_W   = 3;
	localparam int GRAN_SHIFT = 4;
	localparam int OWN_IDX_W  = ADDR_W - GRAN_SHIFT;
	localparam int ROUND_W    = SIZE_W + 1;
	localparam int CLS_W      = ROUND_W - GRAN_SHIFT;

	localparam logic [LIMIT_W-1:0] ADDR_SPACE  = LIMIT_W'(1) << ADDR_W;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);

	localparam logic [STATUS_W-1:0] ST_REUSED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FRESH      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNED  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd6;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SIZE_W-1:0] size_bytes;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   granted_address;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic                clear;
		logic                load;
		logic                rd_first;
		logic                fresh;
		logic                pop;
		logic                reuse;
		logic                rel_fill_rd;
		logic                push_free;
		logic                set_res;
		logic [STATUS_W-1:0] code;
		logic                emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic is_rel;
		logic early_fail;
		logic fill_zero;
		logic fill_full;
		logic bump_over;
		logic owner_bad;
	} sts_t;

endpackage

/* design/scba_ctrl.sv */
// Sequencing state machine of the size-class block allocator.
module scba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  scba_pkg::sts_t sts,
	output scba_pkg::cmd_t cmd
);
	import scba_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_STEP2 = 3'd3;
	localparam logic [2:0] S_STEP3 = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.early_fail) begin
					cmd.set_res = 1'b1;
					cmd.code    = sts.is_rel ? ST_NOT_OWNED : ST_TOO_LARGE;
					state_d     = S_DONE;
				end else begin
					cmd.rd_first = 1'b1;
					state_d      = S_STEP2;
				end
			end
			S_STEP2: begin
				if (!sts.is_rel) begin
					if (!sts.fill_zero) begin
						cmd.pop = 1'b1;
						state_d = S_STEP3;
					end else if (sts.bump_over) begin
						cmd.set_res = 1'b1;
						cmd.code    = ST_FULL;
						state_d     = S_DONE;
					end else begin
						cmd.fresh = 1'b1;
						state_d   = S_DONE;
					end
				end else if (sts.owner_bad) begin
					cmd.set_res = 1'b1;
					cmd.code    = ST_NOT_OWNED;
					state_d     = S_DONE;
				end else begin
					cmd.rel_fill_rd = 1'b1;
					state_d         = S_STEP3;
				end
			end
			S_STEP3: begin
				if (!sts.is_rel) begin
					cmd.reuse = 1'b1;
				end else if (sts.fill_full) begin
					cmd.set_res = 1'b1;
					cmd.code    = ST_STACK_FULL;
				end else begin
					cmd.push_free = 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/scba_dpath.sv */
// Datapath of the size-class block allocator: request decode, bump pointer and memories.
module scba_dpath #(
	parameter int NUM_CLASSES = 256,
	parameter int STACK_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scba_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  scba_pkg::req_t                 req_word,
	output scba_pkg::rsp_t                 rsp_word,
	input  scba_pkg::cmd_t                 cmd,
	output scba_pkg::sts_t                 sts
);
	import scba_pkg::*;

	localparam int CIDX_W    = $clog2(NUM_CLASSES);
	localparam int OWN_W     = $clog2(NUM_CLASSES + 1);
	localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int STK_AW    = CIDX_W + SIDX_W;
	localparam int STK_DEPTH = NUM_CLASSES * (2 ** SIDX_W);
	localparam int OWN_DEPTH = 2 ** OWN_IDX_W;

	// item registers
	logic                 is_rel_q;
	logic [CIDX_W-1:0]    cls_q;
	logic [ROUND_W-1:0]   rounded_q;
	logic [ADDR_W-1:0]    addr_q;
	logic                 too_large_q;
	logic                 addr_bad_q;

	logic [LIMIT_W-1:0]   arena_limit_q;
	logic [LIMIT_W-1:0]   bump_q;
	logic [OWN_IDX_W-1:0] clr_q;

	logic [OWN_W-1:0]     owner_mem [OWN_DEPTH];
	logic [FILL_W-1:0]    fill_mem  [NUM_CLASSES];
	logic [ADDR_W-1:0]    stack_mem [STK_DEPTH];

	logic [OWN_W-1:0]     own_rd_q;
	logic [FILL_W-1:0]    fill_rd_q;
	logic [ADDR_W-1:0]    stk_rd_q;

	rsp_t                 res_q;
	rsp_t                 rsp_q;

	// decode
	logic [SIZE_W-1:0]    size_eff;
	logic [ROUND_W-1:0]   rounded_d;
	logic [CLS_W-1:0]     cls_full;

	always_comb begin
		size_eff  = (req_word.size_bytes == '0) ? SIZE_W'(16) : req_word.size_bytes;
		rounded_d = ({1'b0, size_eff} + ROUND_W'(15)) & ~ROUND_W'(15);
		cls_full  = rounded_d[ROUND_W-1:GRAN_SHIFT];
	end

	// derived values
	logic [LIMIT_W-1:0]   limit_eff;
	logic [LIMIT_W:0]     bump_end;
	logic [OWN_W-1:0]     own_dec;
	logic [CIDX_W-1:0]    own_cls;
	logic [FILL_W-1:0]    fill_dec;
	logic [FILL_W-1:0]    fill_inc;
	logic [OWN_W-1:0]     cls_tag;

	always_comb begin
		limit_eff = (arena_limit_q > ADDR_SPACE) ? ADDR_SPACE : arena_limit_q;
		bump_end  = {1'b0, bump_q} + (LIMIT_W + 1)'(rounded_q);
		own_dec   = own_rd_q - 1'b1;
		own_cls   = CIDX_W'(own_dec);
		fill_dec  = fill_rd_q - 1'b1;
		fill_inc  = fill_rd_q + 1'b1;
		cls_tag   = OWN_W'({1'b0, cls_q}) + 1'b1;
	end

	always_comb begin
		sts.clear_done = &clr_q;
		sts.is_rel     = is_rel_q;
		sts.early_fail = is_rel_q ? addr_bad_q : too_large_q;
		sts.fill_zero  = (fill_rd_q == '0);
		sts.fill_full  = (fill_rd_q >= FILL_W'(STACK_DEPTH));
		sts.bump_over  = (bump_end > {1'b0, limit_eff});
		sts.owner_bad  = (own_rd_q == '0) || (own_rd_q > OWN_W'(NUM_CLASSES));
	end

	// memory port selection
	logic                 own_we;
	logic [OWN_IDX_W-1:0] own_wa;
	logic [OWN_W-1:0]     own_wd;
	logic                 fill_we;
	logic [CIDX_W-1:0]    fill_wa;
	logic [FILL_W-1:0]    fill_wd;
	logic                 fill_re;
	logic [CIDX_W-1:0]    fill_ra;
	logic                 own_re;
	logic [STK_AW-1:0]    stk_wa;
	logic [STK_AW-1:0]    stk_ra;

	always_comb begin
		own_we  = 1'b0;
		own_wa  = addr_q[ADDR_W-1:GRAN_SHIFT];
		own_wd  = '0;
		fill_we = 1'b0;
		fill_wa = cls_q;
		fill_wd = '0;
		if (cmd.clear) begin
			own_we  = 1'b1;
			own_wa  = clr_q;
			fill_we = (clr_q < OWN_IDX_W'(NUM_CLASSES));
			fill_wa = clr_q[CIDX_W-1:0];
		end else if (cmd.fresh) begin
			own_we = 1'b1;
			own_wa = bump_q[ADDR_W-1:GRAN_SHIFT];
			own_wd = cls_tag;
		end else if (cmd.reuse) begin
			own_we = 1'b1;
			own_wa = stk_rd_q[ADDR_W-1:GRAN_SHIFT];
			own_wd = cls_tag;
		end else if (cmd.push_free) begin
			own_we  = 1'b1;
			fill_we = 1'b1;
			fill_wd = fill_inc;
		end else if (cmd.pop) begin
			fill_we = 1'b1;
			fill_wd = fill_dec;
		end
		own_re  = cmd.rd_first && is_rel_q;
		fill_re = (cmd.rd_first && !is_rel_q) || cmd.rel_fill_rd;
		fill_ra = cmd.rel_fill_rd ? own_cls : cls_q;
		stk_wa  = {cls_q, fill_rd_q[SIDX_W-1:0]};
		stk_ra  = {cls_q, fill_dec[SIDX_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			owner_mem[own_wa] <= own_wd;
		end
		if (own_re) begin
			own_rd_q <= owner_mem[addr_q[ADDR_W-1:GRAN_SHIFT]];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_wa] <= fill_wd;
		end
		if (fill_re) begin
			fill_rd_q <= fill_mem[fill_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_free) begin
			stack_mem[stk_wa] <= addr_q;
		end
		if (cmd.pop) begin
			stk_rd_q <= stack_mem[stk_ra];
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_rel_q    <= (req_word.req_type == REQ_RELEASE);
			cls_q       <= CIDX_W'(cls_full);
			rounded_q   <= rounded_d;
			addr_q      <= req_word.block_address;
			too_large_q <= (cls_full >= CLS_W'(NUM_CLASSES));
			addr_bad_q  <= (req_word.block_address[GRAN_SHIFT-1:0] != '0);
		end else if (cmd.rel_fill_rd) begin
			cls_q <= own_cls;
		end
		if (cmd.set_res) begin
			res_q <= '{granted_address: '0, status: cmd.code};
		end else if (cmd.fresh) begin
			res_q <= '{granted_address: bump_q[ADDR_W-1:0], status: ST_FRESH};
		end else if (cmd.reuse) begin
			res_q <= '{granted_address: stk_rd_q, status: ST_REUSED};
		end else if (cmd.push_free) begin
			res_q <= '{granted_address: '0, status: ST_RELEASED};
		end
		if (cmd.emit) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_limit_q <= LIMIT_RESET;
			bump_q        <= '0;
			clr_q         <= '0;
		end else begin
			if (cfg_we) begin
				arena_limit_q <= cfg_wdata;
			end
			if (cmd.fresh) begin
				bump_q <= bump_end[LIMIT_W-1:0];
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign rsp_word = rsp_q;

endmodule

/* design/size_class_block_allocator.sv */
// Top level of the size-class block allocator.
// Allocates blocks by 16-byte size class, reusing freed blocks of a class before
// advancing a bump pointer, and takes them back through an owner table. After
// reset the block runs a clearing pass over all 65536 entries of the owner table (and
// the per-class stack counts) with req_stall held high; configuration writes are
// taken throughout. An accepted request holds req_stall high until it is done:
// a rejected size or misaligned release finishes after the decode step, the
// others walk the chain of registered reads of owner table, stack count and
// stack entry, and the result word is handed to the output register once that
// register is free. One result word comes out for every request, in order.
module size_class_block_allocator #(
	parameter int NUM_CLASSES = 256,
	parameter int STACK_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [scba_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  scba_pkg::req_t               req_word,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output scba_pkg::rsp_t               rsp_word
);
	import scba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	scba_dpath #(
		.NUM_CLASSES (NUM_CLASSES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_word  (req_word),
		.rsp_word  (rsp_word),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef NO_ASSERTIONS
	// no request is taken while the clearing pass runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> req_stall)
		else $error("request accepted during clearing pass");

	// a result word never overwrites one still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp_valid || !rsp_stall))
		else $error("pending result word overwritten");

	// at most one result source per cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fresh, cmd.reuse, cmd.push_free, cmd.set_res}))
		else $error("more than one result source");

	// a result is never emitted directly after a request was loaded
	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !cmd.emit)
		else $error("result emitted right after load");
`endif

endmodule
